FILE: hw/rtl/acs_pkg.sv
`default_nettype none
package acs_pkg;

  localparam logic [15:0] SLOW_INTERVAL_RST = 16'd1000;
  localparam logic [15:0] MIN_CONV_RST      = 16'd1200;
  localparam logic [15:0] TIMEOUT_RST       = 16'd5000;

  typedef enum logic [1:0] {
    TASK_HV_V = 2'd0,
    TASK_HV_I = 2'd1,
    TASK_LV   = 2'd2,
    TASK_TEMP = 2'd3
  } task_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_HV   = 2'd1,
    KIND_LV   = 2'd2,
    KIND_TEMP = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_SLOW_INTERVAL = 3'd0,
    REG_MIN_CONV      = 3'd1,
    REG_TIMEOUT       = 3'd2,
    REG_HV_V_CHAN     = 3'd3,
    REG_HV_I_CHAN     = 3'd4,
    REG_LV_CHAN       = 3'd5,
    REG_TEMP_CHAN     = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [15:0]       slow_interval_ms;
    logic [15:0]       min_conversion_us;
    logic [15:0]       timeout_us;
    logic [3:0][1:0]   chan_sel;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic [31:0]        now_us;
    logic               device_ready;
    logic               conversion_ready;
    logic               read_ok;
    logic signed [15:0] raw_sample;
    logic               start_accepted;
  } in_item_t;

  typedef struct packed {
    logic               err_flag;
    logic               start_issued;
    logic [1:0]         start_channel;
    logic [1:0]         published_kind;
    logic signed [15:0] primary_raw;
    logic signed [15:0] secondary_raw;
    logic               hv_valid;
    logic               lv_mark;
    logic               temp_mark;
  } out_item_t;

  function automatic logic slow_due(input logic [31:0] last, input logic [31:0] now,
                                    input logic [15:0] interval);
    logic [31:0] diff;
    diff = now - last;
    return (last == 32'd0) || (diff >= {16'd0, interval});
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/acs_cfg.sv
`default_nettype none
module acs_cfg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [15:0]   cfg_wdata,
  output acs_pkg::cfg_t      cfg
);

  acs_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (acs_pkg::reg_idx_t'(cfg_index))
        acs_pkg::REG_SLOW_INTERVAL: cfg_nxt.slow_interval_ms  = cfg_wdata;
        acs_pkg::REG_MIN_CONV:      cfg_nxt.min_conversion_us = cfg_wdata;
        acs_pkg::REG_TIMEOUT:       cfg_nxt.timeout_us        = cfg_wdata;
        acs_pkg::REG_HV_V_CHAN:     cfg_nxt.chan_sel[acs_pkg::TASK_HV_V] = cfg_wdata[1:0];
        acs_pkg::REG_HV_I_CHAN:     cfg_nxt.chan_sel[acs_pkg::TASK_HV_I] = cfg_wdata[1:0];
        acs_pkg::REG_LV_CHAN:       cfg_nxt.chan_sel[acs_pkg::TASK_LV]   = cfg_wdata[1:0];
        acs_pkg::REG_TEMP_CHAN:     cfg_nxt.chan_sel[acs_pkg::TASK_TEMP] = cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slow_interval_ms  <= acs_pkg::SLOW_INTERVAL_RST;
      cfg_r.min_conversion_us <= acs_pkg::MIN_CONV_RST;
      cfg_r.timeout_us        <= acs_pkg::TIMEOUT_RST;
      cfg_r.chan_sel[acs_pkg::TASK_HV_V] <= 2'd0;
      cfg_r.chan_sel[acs_pkg::TASK_HV_I] <= 2'd1;
      cfg_r.chan_sel[acs_pkg::TASK_LV]   <= 2'd2;
      cfg_r.chan_sel[acs_pkg::TASK_TEMP] <= 2'd3;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

FILE: hw/rtl/acs_step.sv
`default_nettype none
module acs_step (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 fire,
  input  wire acs_pkg::cfg_t        cfg,
  input  wire acs_pkg::in_item_t    item,
  output acs_pkg::out_item_t        res
);

  logic                converting_r, converting_nxt;
  acs_pkg::task_t      cur_task_r, cur_task_nxt;
  acs_pkg::task_t      next_task_r, next_task_nxt;
  logic [31:0]         start_us_r, start_us_nxt;
  logic [31:0]         last_lv_r, last_lv_nxt;
  logic [31:0]         last_temp_r, last_temp_nxt;
  logic [15:0]         held_raw_r, held_raw_nxt;
  logic                held_vld_r, held_vld_nxt;
  logic [2:0]          marks_r, marks_nxt;

  always_comb begin
    logic [31:0]         elapsed;
    logic                do_start;
    acs_pkg::kind_t      kind;
    logic signed [15:0]  prim;
    logic signed [15:0]  sec;
    acs_pkg::task_t      sel;

    converting_nxt = converting_r;
    cur_task_nxt   = cur_task_r;
    next_task_nxt  = next_task_r;
    start_us_nxt   = start_us_r;
    last_lv_nxt    = last_lv_r;
    last_temp_nxt  = last_temp_r;
    held_raw_nxt   = held_raw_r;
    held_vld_nxt   = held_vld_r;
    marks_nxt      = marks_r;
    res            = '0;
    do_start       = 1'b0;
    kind           = acs_pkg::KIND_NONE;
    prim           = '0;
    sec            = '0;
    sel            = next_task_r;
    elapsed        = item.now_us - start_us_r;

    if (!item.device_ready) begin
      marks_nxt     = '0;
      held_vld_nxt  = 1'b0;
      res.err_flag  = 1'b1;
    end else if (!converting_r) begin
      do_start = 1'b1;
    end else if (elapsed < {16'd0, cfg.min_conversion_us}) begin
      // still converting
    end else if (!item.conversion_ready) begin
      if (elapsed >= {16'd0, cfg.timeout_us}) begin
        converting_nxt = 1'b0;
        marks_nxt      = '0;
        held_vld_nxt   = 1'b0;
        res.err_flag   = 1'b1;
      end
    end else if (!item.read_ok) begin
      converting_nxt = 1'b0;
      marks_nxt      = '0;
      held_vld_nxt   = 1'b0;
      res.err_flag   = 1'b1;
    end else begin
      case (cur_task_r)
        acs_pkg::TASK_HV_V: begin
          held_raw_nxt = item.raw_sample;
          held_vld_nxt = 1'b1;
        end
        acs_pkg::TASK_HV_I: begin
          if (held_vld_r) begin
            kind         = acs_pkg::KIND_HV;
            prim         = held_raw_r;
            sec          = item.raw_sample;
            marks_nxt[0] = 1'b1;
            held_vld_nxt = 1'b0;
          end
        end
        acs_pkg::TASK_LV: begin
          kind         = acs_pkg::KIND_LV;
          prim         = item.raw_sample;
          marks_nxt[1] = 1'b1;
          last_lv_nxt  = item.now_ms;
        end
        default: begin
          kind          = acs_pkg::KIND_TEMP;
          prim          = item.raw_sample;
          marks_nxt[2]  = 1'b1;
          last_temp_nxt = item.now_ms;
        end
      endcase
      converting_nxt = 1'b0;
      do_start       = 1'b1;
    end

    if (do_start) begin
      case (sel)
        acs_pkg::TASK_HV_V: next_task_nxt = acs_pkg::TASK_HV_I;
        acs_pkg::TASK_HV_I: begin
          if (acs_pkg::slow_due(last_lv_nxt, item.now_ms, cfg.slow_interval_ms)) begin
            next_task_nxt = acs_pkg::TASK_LV;
          end else if (acs_pkg::slow_due(last_temp_nxt, item.now_ms,
                                         cfg.slow_interval_ms)) begin
            next_task_nxt = acs_pkg::TASK_TEMP;
          end else begin
            next_task_nxt = acs_pkg::TASK_HV_V;
          end
        end
        default: next_task_nxt = acs_pkg::TASK_HV_V;
      endcase
      cur_task_nxt      = sel;
      res.start_issued  = 1'b1;
      res.start_channel = cfg.chan_sel[sel];
      if (!item.start_accepted) begin
        converting_nxt = 1'b0;
        marks_nxt      = '0;
        held_vld_nxt   = 1'b0;
        res.err_flag   = 1'b1;
      end else begin
        start_us_nxt       = item.now_us;
        converting_nxt     = 1'b1;
        res.published_kind = kind;
        res.primary_raw    = prim;
        res.secondary_raw  = sec;
      end
    end

    res.hv_valid  = marks_nxt[0];
    res.lv_mark   = marks_nxt[1];
    res.temp_mark = marks_nxt[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      converting_r <= 1'b0;
      cur_task_r   <= acs_pkg::TASK_HV_V;
      next_task_r  <= acs_pkg::TASK_HV_V;
      start_us_r   <= '0;
      last_lv_r    <= '0;
      last_temp_r  <= '0;
      held_raw_r   <= '0;
      held_vld_r   <= 1'b0;
      marks_r      <= '0;
    end else if (fire) begin
      converting_r <= converting_nxt;
      cur_task_r   <= cur_task_nxt;
      next_task_r  <= next_task_nxt;
      start_us_r   <= start_us_nxt;
      last_lv_r    <= last_lv_nxt;
      last_temp_r  <= last_temp_nxt;
      held_raw_r   <= held_raw_nxt;
      held_vld_r   <= held_vld_nxt;
      marks_r      <= marks_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/adc_channel_conversion_sequencer_core.sv
// Path: an accepted input is held in the input register, then stepped into the result
// register, which drives out_valid; the step waits while a result is held and not taken.
// Throughput: one item per cycle while the result side keeps out_ready high.
// With both registers full and out_ready low, in_ready drops until the result is taken.
// Reset (rst_n, synchronous, active low) empties both registers, clears sequencer
// state and valid marks, and loads the default configuration.
`default_nettype none
module adc_channel_conversion_sequencer_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire acs_pkg::in_item_t    in_data,
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output acs_pkg::out_item_t        out_data,
  input  wire logic                 cfg_we,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [15:0]          cfg_wdata
);

  acs_pkg::cfg_t       cfg;
  acs_pkg::in_item_t   in_data_r, in_data_nxt;
  logic                in_vld_r, in_vld_nxt;
  acs_pkg::out_item_t  out_data_r, out_data_nxt;
  logic                out_vld_r, out_vld_nxt;
  acs_pkg::out_item_t  step_res;
  logic                adv;
  logic                out_free;

  acs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  acs_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (adv),
    .cfg   (cfg),
    .item  (in_data_r),
    .res   (step_res)
  );

  assign out_free = !out_vld_r || out_ready;
  assign adv      = in_vld_r && out_free;
  assign in_ready = !in_vld_r || adv;

  always_comb begin
    in_vld_nxt   = in_vld_r;
    in_data_nxt  = in_data_r;
    out_vld_nxt  = out_vld_r;
    out_data_nxt = out_data_r;
    if (adv) begin
      in_vld_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      in_vld_nxt  = 1'b1;
      in_data_nxt = in_data;
    end
    if (out_vld_r && out_ready) begin
      out_vld_nxt = 1'b0;
    end
    if (adv) begin
      out_vld_nxt  = 1'b1;
      out_data_nxt = step_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_data_r  <= in_data_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire
